// File: hw/rtl/tgrvr_pkg.sv
// ----------------------------------------------------------------------------
// tgrvr_pkg
// Shared types and constants of the two-group running variance ratio block.
// ----------------------------------------------------------------------------
`default_nettype none

package tgrvr_pkg;

  // fixed widths of the arithmetic
  localparam int unsigned MEAN_W  = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned HI_W    = 21;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned RATIO_W = 32;
  localparam int unsigned PIDX_W  = 6;
  localparam int unsigned DIVN_W  = 80;  // dividend of the shared divider
  localparam int unsigned DIVD_W  = 64;  // divisor of the shared divider
  localparam int unsigned DIVC_W  = 7;   // iteration count

  localparam logic [HI_W-1:0]  HI_RESET = 21'd500;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_DST,
    S_DIV1,
    S_DIV2,
    S_END,
    S_MOD,
    S_CPR,
    S_CPW,
    S_CHK,
    S_ERD,
    S_EDIV,
    S_EWAIT,
    S_EOUT
  } state_t;

  // what the shared divider is working on
  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_SUM,
    DIV_MOD,
    DIV_RATIO
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     upd_load;
    logic     lat_delta;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     lat_qd;
    logic     wr_upd;
    logic     idx_clr;
    logic     idx_inc;
    logic     cp_rd;
    logic     cp_wr;
    logic     set_snap;
    logic     clr_snap;
    logic     em_rd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic n_le1;
    logic last_pt;
    logic mod_ok;
    logic div_done;
    logic rem_zero;
    logic emit_ok;
    logic idx_last;
    logic den_zero;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/tgrvr_ram.sv
// ----------------------------------------------------------------------------
// tgrvr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tgrvr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tgrvr_div.sv
// ----------------------------------------------------------------------------
// tgrvr_div
// Shared restoring divider, one quotient bit per cycle, variable bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module tgrvr_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [tgrvr_pkg::DIVN_W-1:0]   num,    // left-aligned dividend
  input  wire logic [tgrvr_pkg::DIVD_W-1:0]   den,
  input  wire logic [tgrvr_pkg::DIVC_W-1:0]   nbits,
  output logic                                done,
  output logic      [tgrvr_pkg::DIVN_W-1:0]   quo,
  output logic      [tgrvr_pkg::DIVD_W-1:0]   rem
);

  logic [tgrvr_pkg::DIVN_W-1:0] num_r, quo_r;
  logic [tgrvr_pkg::DIVD_W-1:0] den_r, rem_r;
  logic [tgrvr_pkg::DIVC_W-1:0] cnt_r;
  logic                         busy_r, done_r;
  logic [tgrvr_pkg::DIVD_W:0]   rem_w, diff_w;
  logic                         ge;

  // one restoring step
  always_comb begin
    rem_w  = {rem_r, num_r[tgrvr_pkg::DIVN_W-1]};
    diff_w = rem_w - {1'b0, den_r};
    ge     = (rem_w >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= nbits;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == tgrvr_pkg::DIVC_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[tgrvr_pkg::DIVN_W-2:0], 1'b0};
      rem_r <= ge ? diff_w[tgrvr_pkg::DIVD_W-1:0] : rem_w[tgrvr_pkg::DIVD_W-1:0];
      quo_r <= {quo_r[tgrvr_pkg::DIVN_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/tgrvr_dpath.sv
// ----------------------------------------------------------------------------
// tgrvr_dpath
// Datapath: counters, mean/sum/snapshot stores, Welford update, ratio output.
// ----------------------------------------------------------------------------
`default_nettype none

module tgrvr_dpath #(
  parameter int unsigned NSAMPLES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tgrvr_pkg::cmd_t                   cmd,
  output tgrvr_pkg::sts_t                        sts,
  input  wire logic                              in_group,
  input  wire logic [tgrvr_pkg::SMP_W-1:0]       in_sample,
  input  wire logic                              cfg_we,
  input  wire logic [tgrvr_pkg::HI_W-1:0]        cfg_hi,
  output logic      [tgrvr_pkg::RATIO_W-1:0]     out_ratio,
  output logic      [tgrvr_pkg::PIDX_W-1:0]      out_pidx,
  output logic                                   out_last
);

  localparam int unsigned PW = (NSAMPLES > 1) ? $clog2(NSAMPLES) : 1;
  localparam int unsigned AW = $clog2(2 * NSAMPLES);
  localparam logic [PW-1:0] P_LAST = PW'(NSAMPLES - 1);

  // configuration and counters
  logic [tgrvr_pkg::HI_W-1:0]  hi_r;
  logic [PW-1:0]               pc_r, p_r, idx_r;
  logic                        g_r;
  logic [tgrvr_pkg::SMP_W-1:0] x_r;
  logic [tgrvr_pkg::CNT_W-1:0] tc_r [2];
  logic [tgrvr_pkg::CNT_W-1:0] snc_r [2];
  logic [tgrvr_pkg::CNT_W-1:0] n;

  assign n = tc_r[g_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r   <= tgrvr_pkg::HI_RESET;
      pc_r   <= '0;
      tc_r   <= '{default: '0};
      snc_r  <= '{default: '0};
      idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        hi_r <= cfg_hi;
      end
      if (cmd.accept) begin
        pc_r <= (pc_r == P_LAST) ? '0 : pc_r + 1'b1;
        if (pc_r == '0 && tc_r[in_group] != tgrvr_pkg::CNT_MAX) begin
          tc_r[in_group] <= tc_r[in_group] + 1'b1;
        end
      end
      if (cmd.set_snap) begin
        snc_r[g_r] <= n;
      end
      if (cmd.clr_snap) begin
        snc_r <= '{default: '0};
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      g_r <= in_group;
      x_r <= in_sample;
      p_r <= pc_r;
    end
  end

  // store addressing: group 1 sits above group 0
  logic [AW-1:0] acc_addr, upd_addr, cp_addr;
  assign acc_addr = in_group ? AW'(NSAMPLES) + AW'(pc_r) : AW'(pc_r);
  assign upd_addr = g_r ? AW'(NSAMPLES) + AW'(p_r) : AW'(p_r);
  assign cp_addr  = g_r ? AW'(NSAMPLES) + AW'(idx_r) : AW'(idx_r);

  logic [tgrvr_pkg::MEAN_W-1:0] mean_rd, mean_wd;
  logic [tgrvr_pkg::SUM_W-1:0]  sum_rd, sum_wd, snap0_rd, snap1_rd;
  logic                         upd_we;

  assign upd_we = cmd.upd_load | cmd.wr_upd;

  tgrvr_ram #(.WIDTH(tgrvr_pkg::MEAN_W), .DEPTH(2 * NSAMPLES)) u_mean_ram (
    .clk   (clk),
    .we    (upd_we),
    .waddr (upd_addr),
    .wdata (mean_wd),
    .re    (cmd.accept),
    .raddr (acc_addr),
    .rdata (mean_rd)
  );

  tgrvr_ram #(.WIDTH(tgrvr_pkg::SUM_W), .DEPTH(2 * NSAMPLES)) u_sum_ram (
    .clk   (clk),
    .we    (upd_we),
    .waddr (upd_addr),
    .wdata (sum_wd),
    .re    (cmd.accept | cmd.cp_rd),
    .raddr (cmd.cp_rd ? cp_addr : acc_addr),
    .rdata (sum_rd)
  );

  tgrvr_ram #(.WIDTH(tgrvr_pkg::SUM_W), .DEPTH(NSAMPLES)) u_snap0_ram (
    .clk   (clk),
    .we    (cmd.cp_wr & ~g_r),
    .waddr (idx_r),
    .wdata (sum_rd),
    .re    (cmd.em_rd),
    .raddr (idx_r),
    .rdata (snap0_rd)
  );

  tgrvr_ram #(.WIDTH(tgrvr_pkg::SUM_W), .DEPTH(NSAMPLES)) u_snap1_ram (
    .clk   (clk),
    .we    (cmd.cp_wr & g_r),
    .waddr (idx_r),
    .wdata (sum_rd),
    .re    (cmd.em_rd),
    .raddr (idx_r),
    .rdata (snap1_rd)
  );

  // delta = x*2^16 - mean, kept as sign and magnitude (magnitude < 2^32)
  logic signed [33:0] delta_w;
  logic [33:0]        dabs_w;
  logic [31:0]        d_r;
  logic               neg_r;
  logic [63:0]        dd_r;
  logic [31:0]        qd_r;

  always_comb begin
    delta_w = {{2{x_r[tgrvr_pkg::SMP_W-1]}}, x_r, 16'b0}
              - {{2{mean_rd[tgrvr_pkg::MEAN_W-1]}}, mean_rd};
    dabs_w  = delta_w[33] ? -delta_w : delta_w;
  end

  // shared divider
  logic [tgrvr_pkg::DIVN_W-1:0] div_num, div_quo;
  logic [tgrvr_pkg::DIVD_W-1:0] div_den, div_rem;
  logic [tgrvr_pkg::DIVC_W-1:0] div_nb;
  logic                         div_done;

  always_comb begin
    case (cmd.div_sel)
      tgrvr_pkg::DIV_MEAN: begin
        div_num = {d_r, 48'b0};
        div_den = {32'b0, n};
        div_nb  = tgrvr_pkg::DIVC_W'(32);
      end
      tgrvr_pkg::DIV_SUM: begin
        div_num = {dd_r[63:16], 32'b0};
        div_den = {32'b0, n};
        div_nb  = tgrvr_pkg::DIVC_W'(48);
      end
      tgrvr_pkg::DIV_MOD: begin
        div_num = {n, 48'b0};
        div_den = {43'b0, hi_r};
        div_nb  = tgrvr_pkg::DIVC_W'(32);
      end
      default: begin
        div_num = {snap0_rd, 16'b0};
        div_den = snap1_rd;
        div_nb  = tgrvr_pkg::DIVC_W'(80);
      end
    endcase
  end

  tgrvr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nb),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // delta, square and mean quotient registers
  always_ff @(posedge clk) begin
    if (cmd.lat_delta) begin
      d_r   <= dabs_w[31:0];
      neg_r <= delta_w[33];
    end
    if (cmd.mul) begin
      dd_r <= d_r * d_r;
    end
    if (cmd.lat_qd) begin
      qd_r <= div_quo[31:0];
    end
  end

  // write-back values: new mean and saturating sum + q - ceil(q/n)
  logic [47:0] q_w, ceil_w, term_w;
  logic [64:0] s_w;

  always_comb begin
    q_w    = dd_r[63:16];
    ceil_w = div_quo[47:0] + {47'b0, (div_rem != '0)};
    term_w = q_w - ceil_w;
    s_w    = {1'b0, sum_rd} + {17'b0, term_w};
    if (cmd.upd_load) begin
      mean_wd = {x_r, 16'b0};
      sum_wd  = '0;
    end else begin
      mean_wd = neg_r ? mean_rd - qd_r : mean_rd + qd_r;
      sum_wd  = s_w[64] ? '1 : s_w[63:0];
    end
  end

  // result register
  logic [PW+tgrvr_pkg::PIDX_W-1:0] idx_ext;
  assign idx_ext = {{tgrvr_pkg::PIDX_W{1'b0}}, idx_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (snap1_rd == '0) begin
        out_ratio <= '0;
      end else if (div_quo[79:32] != '0) begin
        out_ratio <= '1;
      end else begin
        out_ratio <= div_quo[31:0];
      end
      out_pidx <= idx_ext[tgrvr_pkg::PIDX_W-1:0];
      out_last <= (idx_r == P_LAST);
    end
  end

  // status
  always_comb begin
    sts.n_le1    = (n <= tgrvr_pkg::CNT_W'(1));
    sts.last_pt  = (p_r == P_LAST);
    sts.mod_ok   = (hi_r != '0) && (n != '0);
    sts.div_done = div_done;
    sts.rem_zero = (div_rem == '0);
    sts.emit_ok  = (snc_r[0] != '0) && (snc_r[0] == snc_r[1]);
    sts.idx_last = (idx_r == P_LAST);
    sts.den_zero = (snap1_rd == '0);
  end

endmodule

`default_nettype wire

// File: hw/rtl/tgrvr_ctrl.sv
// ----------------------------------------------------------------------------
// tgrvr_ctrl
// Controller: sequences update, snapshot copy and ratio emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tgrvr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tgrvr_pkg::cmd_t      cmd,
  input  wire tgrvr_pkg::sts_t sts
);

  tgrvr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgrvr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgrvr_pkg::S_IDLE:  if (in_valid) state_nxt = tgrvr_pkg::S_RD;
      tgrvr_pkg::S_RD:    state_nxt = sts.n_le1 ? tgrvr_pkg::S_END : tgrvr_pkg::S_DST;
      tgrvr_pkg::S_DST:   state_nxt = tgrvr_pkg::S_DIV1;
      tgrvr_pkg::S_DIV1:  if (sts.div_done) state_nxt = tgrvr_pkg::S_DIV2;
      tgrvr_pkg::S_DIV2:  if (sts.div_done) state_nxt = tgrvr_pkg::S_END;
      tgrvr_pkg::S_END: begin
        if (!sts.last_pt) begin
          state_nxt = tgrvr_pkg::S_IDLE;
        end else begin
          state_nxt = sts.mod_ok ? tgrvr_pkg::S_MOD : tgrvr_pkg::S_CHK;
        end
      end
      tgrvr_pkg::S_MOD: begin
        if (sts.div_done) begin
          state_nxt = sts.rem_zero ? tgrvr_pkg::S_CPR : tgrvr_pkg::S_CHK;
        end
      end
      tgrvr_pkg::S_CPR:   state_nxt = tgrvr_pkg::S_CPW;
      tgrvr_pkg::S_CPW:   state_nxt = sts.idx_last ? tgrvr_pkg::S_CHK : tgrvr_pkg::S_CPR;
      tgrvr_pkg::S_CHK:   state_nxt = sts.emit_ok ? tgrvr_pkg::S_ERD : tgrvr_pkg::S_IDLE;
      tgrvr_pkg::S_ERD:   state_nxt = tgrvr_pkg::S_EDIV;
      tgrvr_pkg::S_EDIV:  state_nxt = sts.den_zero ? tgrvr_pkg::S_EOUT : tgrvr_pkg::S_EWAIT;
      tgrvr_pkg::S_EWAIT: if (sts.div_done) state_nxt = tgrvr_pkg::S_EOUT;
      tgrvr_pkg::S_EOUT: begin
        if (out_ready) begin
          state_nxt = sts.idx_last ? tgrvr_pkg::S_IDLE : tgrvr_pkg::S_ERD;
        end
      end
      default:            state_nxt = tgrvr_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.div_sel = tgrvr_pkg::DIV_MEAN;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      tgrvr_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tgrvr_pkg::S_RD: begin
        cmd.upd_load  = sts.n_le1;
        cmd.lat_delta = 1'b1;
      end
      tgrvr_pkg::S_DST: begin
        cmd.div_start = 1'b1;
        cmd.mul       = 1'b1;
      end
      tgrvr_pkg::S_DIV1: begin
        cmd.div_sel   = tgrvr_pkg::DIV_SUM;
        cmd.lat_qd    = sts.div_done;
        cmd.div_start = sts.div_done;
      end
      tgrvr_pkg::S_DIV2: begin
        cmd.wr_upd = sts.div_done;
      end
      tgrvr_pkg::S_END: begin
        cmd.div_sel   = tgrvr_pkg::DIV_MOD;
        cmd.div_start = sts.last_pt & sts.mod_ok;
      end
      tgrvr_pkg::S_MOD: begin
        cmd.idx_clr = sts.div_done & sts.rem_zero;
      end
      tgrvr_pkg::S_CPR: begin
        cmd.cp_rd = 1'b1;
      end
      tgrvr_pkg::S_CPW: begin
        cmd.cp_wr    = 1'b1;
        cmd.idx_inc  = ~sts.idx_last;
        cmd.set_snap = sts.idx_last;
      end
      tgrvr_pkg::S_CHK: begin
        cmd.clr_snap = sts.emit_ok;
        cmd.idx_clr  = sts.emit_ok;
      end
      tgrvr_pkg::S_ERD: begin
        cmd.em_rd = 1'b1;
      end
      tgrvr_pkg::S_EDIV: begin
        cmd.div_sel   = tgrvr_pkg::DIV_RATIO;
        cmd.div_start = ~sts.den_zero;
        cmd.out_load  = sts.den_zero;
      end
      tgrvr_pkg::S_EWAIT: begin
        cmd.out_load = sts.div_done;
      end
      tgrvr_pkg::S_EOUT: begin
        out_valid   = 1'b1;
        cmd.idx_inc = out_ready & ~sts.idx_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // a result is never offered while a request is being taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output handshakes overlap");

  // a started division clears the done flag on the next edge
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done not cleared by start");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // snapshot copy only follows a finished modulo test
  a_copy_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgrvr_pkg::S_CPR && $past(state_r) == tgrvr_pkg::S_MOD)
      |-> $past(sts.div_done && sts.rem_zero))
    else $error("snapshot copy without a multiple of the interval");

endmodule

`default_nettype wire

// File: hw/rtl/two_group_running_variance_ratio.sv
// ----------------------------------------------------------------------------
// two_group_running_variance_ratio
// Welford running variance of two trace groups and their per-point ratio.
// ----------------------------------------------------------------------------
// Usage: samples enter on the in_ stream, tuser carrying the group. An
// internal counter places each sample at a point of an NSAMPLES trace. The
// out_ stream carries one ratio per point (tlast on the final point) when
// both groups have taken equal snapshots. cfg_ sets the snapshot interval and
// must be written only while the block is idle; nothing here enforces it.
// Rate: one sample at a time. A first-trace sample needs no division; later
// ones take a 32-bit and a 48-bit pass of the bit-serial divider. The last
// sample of a trace adds a 32-bit pass for the interval test and, on a
// snapshot, a read and a write per point to copy the sums. Each emitted ratio
// takes an 80-bit pass, none on a zero denominator, and waits for out_tready.
// Reset: counters clear and the interval returns to 500; the stores need no
// clearing. While out_tvalid is held by a stalled receiver, in_tready stays
// low and the result holds.
// ----------------------------------------------------------------------------
`default_nettype none

module two_group_running_variance_ratio #(
  parameter int unsigned NSAMPLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample_value
  input  wire logic        in_tuser,   // [0] group_id
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] ratio, [37:32] point_index, zero pad
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [20:0] cfg_data    // [20:0] half_interval
);

  tgrvr_pkg::cmd_t cmd;
  tgrvr_pkg::sts_t sts;
  logic [tgrvr_pkg::RATIO_W-1:0] ratio;
  logic [tgrvr_pkg::PIDX_W-1:0]  pidx;

  assign cfg_ready = 1'b1;

  tgrvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tgrvr_dpath #(.NSAMPLES(NSAMPLES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_group  (in_tuser),
    .in_sample (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_hi    (cfg_data),
    .out_ratio (ratio),
    .out_pidx  (pidx),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, pidx, ratio};

endmodule

`default_nettype wire

// File: tb/two_group_running_variance_ratio_tb.sv
// ----------------------------------------------------------------------------
// two_group_running_variance_ratio_tb
// Drives traces of tagged samples into the variance ratio block, keeps its own
// Welford state for both groups and checks every emitted ratio in order.
// Directed traces cover sample extremes and group changes within a trace,
// including a sample of a group that has no trace yet. Random traces then run
// under several snapshot intervals and three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_group_running_variance_ratio_tb;

  localparam int NPTS      = 64;
  localparam int QUIET_MAX = 20000;
  localparam int SETTLE    = 400;

  typedef struct {
    bit [tgrvr_pkg::RATIO_W-1:0] ratio;
    bit [tgrvr_pkg::PIDX_W-1:0]  point;
    bit                          last;
  } ratio_exp_t;

  // Predicts the ratio stream from the accepted samples
  class ratio_scoreboard;
    bit [tgrvr_pkg::MEAN_W-1:0] mean_q[2*NPTS];
    bit [tgrvr_pkg::SUM_W-1:0]  sum_q[2*NPTS];
    bit [tgrvr_pkg::SUM_W-1:0]  snap_q[2*NPTS];
    bit                         written[2*NPTS];
    int unsigned                traces[2];
    int unsigned                snaps[2];
    int unsigned                point;
    bit [tgrvr_pkg::HI_W-1:0]   half_iv;
    ratio_exp_t                 ratio_q[$];
    int unsigned                emissions;

    function new();
      half_iv = tgrvr_pkg::HI_RESET;
    endfunction

    // a sample of group g at point p must not read a never-written entry
    function bit safe(bit g, int unsigned p);
      int unsigned n;
      n = traces[g];
      if (p == 0 && n != tgrvr_pkg::CNT_MAX) n++;
      return (n <= 1) || written[g*NPTS+p];
    endfunction

    function void welford(int unsigned slot, shortint x, int unsigned n);
      longint     mean, delta, xs;
      bit [63:0]  d, q, term, nn;
      bit [64:0]  s;
      xs = x;
      if (n <= 1) begin
        mean_q[slot] = {x, 16'h0};
        sum_q[slot]  = '0;
        return;
      end
      nn    = n;
      mean  = longint'($signed(mean_q[slot]));
      delta = xs * 65536 - mean;
      mean  = mean + delta / longint'(nn);
      mean_q[slot] = mean[31:0];
      d    = (delta < 0) ? -delta : delta;
      q    = (d * d) >> 16;
      term = (q / nn) * (nn - 1) + ((q % nn) * (nn - 1)) / nn;
      s    = {1'b0, sum_q[slot]} + {1'b0, term};
      sum_q[slot] = s[64] ? '1 : s[63:0];
    endfunction

    function bit [tgrvr_pkg::RATIO_W-1:0] ratio_of(bit [tgrvr_pkg::SUM_W-1:0] num,
                                                   bit [tgrvr_pkg::SUM_W-1:0] den);
      bit [79:0] quo;
      if (den == 0) return '0;
      quo = {num, 16'h0} / {16'h0, den};
      return (quo > 80'hFFFF_FFFF) ? '1 : quo[31:0];
    endfunction

    function void note_sample(bit g, shortint x);
      int unsigned p, n;
      ratio_exp_t  e;
      p = point;
      if (p == 0 && traces[g] != tgrvr_pkg::CNT_MAX) traces[g]++;
      n = traces[g];
      welford(g*NPTS+p, x, n);
      written[g*NPTS+p] = 1'b1;
      if (p == NPTS-1) begin
        point = 0;
        if (half_iv != 0 && n != 0 && n % half_iv == 0) begin
          for (int i = 0; i < NPTS; i++) snap_q[g*NPTS+i] = sum_q[g*NPTS+i];
          snaps[g] = n;
        end
        if (snaps[0] > 0 && snaps[0] == snaps[1]) begin
          for (int i = 0; i < NPTS; i++) begin
            e.ratio = ratio_of(snap_q[i], snap_q[NPTS+i]);
            e.point = tgrvr_pkg::PIDX_W'(i);
            e.last  = (i == NPTS-1);
            ratio_q.push_back(e);
          end
          emissions++;
          snaps[0] = 0;
          snaps[1] = 0;
        end
      end else begin
        point = p + 1;
      end
    endfunction

    // returns an empty string when the ratio matches the oldest expectation
    function string check_ratio(bit [tgrvr_pkg::RATIO_W-1:0] r,
                                bit [tgrvr_pkg::PIDX_W-1:0] pi, bit l);
      ratio_exp_t e;
      if (ratio_q.size() == 0)
        return $sformatf("unexpected ratio %h point %0d", r, pi);
      e = ratio_q.pop_front();
      if (r != e.ratio || pi != e.point || l != e.last)
        return $sformatf("point %0d: got ratio %h idx %0d last %0b, want %h %0d %0b",
                         e.point, r, pi, l, e.ratio, e.point, e.last);
      return "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] sample_value
  logic        in_tuser = 1'b0; // [0] group_id
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] ratio, [37:32] point_index, zero pad
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [20:0] cfg_data = '0;   // [20:0] half_interval

  ratio_scoreboard sb = new();
  int errors, samples_sent, ratios_seen, quiet;
  int tx_idle, rx_idle;

  always #2 clk = ~clk;

  two_group_running_variance_ratio #(.NSAMPLES(NPTS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // result side: check accepted ratios, stall at random
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      msg = sb.check_ratio(out_tdata[31:0], out_tdata[37:32], out_tlast);
      if (msg != "") report_mismatch(msg);
      ratios_seen++;
    end
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("timeout: no request accepted for %0d cycles", QUIET_MAX);
      $display("two_group_running_variance_ratio_tb: FAIL");
      $finish;
    end
  end

  task automatic write_interval(bit [tgrvr_pkg::HI_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.half_iv = v;
  endtask

  // one sample request; in_tvalid stays high when no gap follows
  task automatic send_sample(bit g, shortint x);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    in_tuser  <= g;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(g, x);
    samples_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.ratio_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // directed trace: extremes first, a group change at point 5
  task automatic directed_trace(bit tg);
    shortint x;
    for (int p = 0; p < NPTS; p++) begin
      case (p)
        0: x = -32768;
        1: x = 32767;
        2: x = 0;
        3: x = -1;
        4: x = 1;
        default: x = shortint'($urandom);
      endcase
      send_sample((p == 5) ? ~tg : tg, x);
    end
  endtask

  // random trace with content style chosen per trace, rare safe group flips
  task automatic random_trace(bit tg);
    int      style;
    shortint base, x;
    bit      g;
    style = $urandom_range(2);
    base  = shortint'($urandom);
    for (int p = 0; p < NPTS; p++) begin
      case (style)
        0: x = shortint'($urandom);
        1: x = shortint'(int'(base) + int'($urandom_range(4)) - 2);
        default: x = base;
      endcase
      g = tg;
      if (p > 0 && $urandom_range(99) < 4 && sb.safe(~tg, p) && sb.written[tg*NPTS+p])
        g = ~tg;
      if (!sb.safe(g, p)) g = ~g;
      send_sample(g, x);
    end
  endtask

  initial begin
    bit [tgrvr_pkg::HI_W-1:0] iv[5];
    int                       ntr[5];
    int                       txi[5];
    int                       rxi[5];
    bit                       tg;

    iv  = '{21'd2, 21'd1, 21'd0, 21'd1048576, 21'd1};
    ntr = '{1, 1, 1, 1, 0};
    txi = '{33, 67, 0, 0, 0};
    rxi = '{67, 33, 0, 0, 0};
    tx_idle = 33;
    rx_idle = 67;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // group 0 trace touching group 1 before its first trace, then the reverse
    write_interval(21'd1);
    directed_trace(1'b0);
    directed_trace(1'b1);
    drain();

    tg = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      tx_idle = txi[ph];
      rx_idle = rxi[ph];
      write_interval(iv[ph]);
      for (int t = 0; t < ntr[ph]; t++) begin
        random_trace(tg);
        if ($urandom_range(99) < 80) tg = ~tg;
      end
      drain();
    end

    if (sb.ratio_q.size() > 0)
      report_mismatch($sformatf("%0d ratios never arrived", sb.ratio_q.size()));
    $display("covered %0d samples over intervals 0, 1, 2 and 2^20, three idling patterns",
             samples_sent);
    $display("checked %0d ratios from %0d emitted traces", ratios_seen, sb.emissions);
    if (errors == 0)
      $display("two_group_running_variance_ratio_tb: PASS");
    else
      $display("two_group_running_variance_ratio_tb: FAIL");
    $finish;
  end

endmodule
